// ----- hw/rtl/nsrh_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsrh_pkg
// Shared types and constants for the nearest segment ray hit block.
// ---------------------------------------------------------------------------
package nsrh_pkg;

    localparam int MAX_SEGMENTS = 256;
    localparam int SLOT_W       = 8;
    localparam int COUNT_W      = 9;
    localparam int COORD_W      = 16;
    localparam int DIFF_W       = 17;   // coordinate difference
    localparam int CROSS_W      = 35;   // cross-product term
    localparam int MAG_W        = 34;   // magnitude of a cross-product term
    localparam int NUM_W        = 50;   // s * |a| before the 8-bit fraction shift
    localparam int QUOT_W       = 24;   // hit offset magnitude, 8 fraction bits
    localparam int DIST_W       = 49;
    localparam int DIV_STEPS    = 24;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_CAST  = 1'b1;

    typedef struct packed {
        logic                      opcode;
        logic [SLOT_W-1:0]         slot;
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } t_in_word;

    typedef struct packed {
        logic                hit;
        logic signed [23:0]  hit_x;
        logic signed [23:0]  hit_y;
        logic [DIST_W-1:0]   distance_squared;
        logic [SLOT_W-1:0]   hit_segment;
    } t_out_word;

    typedef struct packed {
        logic signed [COORD_W-1:0] x3;
        logic signed [COORD_W-1:0] y3;
        logic signed [COORD_W-1:0] x4;
        logic signed [COORD_W-1:0] y4;
    } t_seg;

endpackage

// ----- hw/rtl/nsrh_table.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsrh_table
// Wall segment store: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module nsrh_table
    import nsrh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [SLOT_W-1:0] i_waddr,
    input  t_seg              i_wdata,
    input  logic [SLOT_W-1:0] i_raddr,
    output t_seg              o_rdata
);

    t_seg r_mem [MAX_SEGMENTS];
    t_seg r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/nsrh_div.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsrh_div
// Restoring divider: floor((num << 8) / den), one quotient bit per cycle.
// The quotient is known to fit in QUOT_W bits.
// ---------------------------------------------------------------------------
module nsrh_div
    import nsrh_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [MAG_W-1:0]  i_den,
    output logic              o_done,
    output logic [QUOT_W-1:0] o_quot
);

    logic              r_run;
    logic              r_done;
    logic [4:0]        r_cnt;
    logic [MAG_W-1:0]  r_rem;
    logic [MAG_W-1:0]  r_den;
    logic [QUOT_W-1:0] r_low;
    logic [QUOT_W-1:0] r_q;

    logic [MAG_W:0]    w_rem2;
    logic [MAG_W:0]    w_diff;
    logic              w_ge;

    // one trial subtract per cycle
    assign w_rem2 = {r_rem, r_low[QUOT_W-1]};
    assign w_diff = w_rem2 - {1'b0, r_den};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= 5'(DIV_STEPS - 1);
            end else if (r_run) begin
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == '0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: top bits of the shifted numerator start below den
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:16];
            r_low <= {i_num[15:0], 8'd0};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_run) begin
            r_rem <= w_ge ? w_diff[MAG_W-1:0] : w_rem2[MAG_W-1:0];
            r_low <= {r_low[QUOT_W-2:0], 1'b0};
            r_q   <= {r_q[QUOT_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

// ----- hw/rtl/nearest_segment_ray_hit_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nearest_segment_ray_hit_top
// Stores wall segments and finds the nearest wall that a cast ray meets.
//
//   channel  | signals                  | direction | notes
//   ---------+--------------------------+-----------+---------------------------
//   command  | start, busy, i_word      | in        | taken when start && !busy
//   result   | o_valid, o_word          | out       | one cycle, no back-pressure
//   config   | i_cfg_we, i_cfg_data     | in        | segment_count, no read-back
//
// A write word is stored without raising busy. A cast examines each segment
// in turn; a segment that is hit adds two 24-step divisions
// on the shared divider and four products on the shared multiplier, and the
// result strobe follows the scan. The single multiplier and divider set the pace.
// Reset is synchronous, active low; the segment store itself is not cleared.
// Results cannot be stalled; a new word is taken as soon as busy drops.
// ---------------------------------------------------------------------------
module nearest_segment_ray_hit_top
    import nsrh_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  t_in_word           i_word,
    input  logic               i_cfg_we,
    input  logic [COUNT_W-1:0] i_cfg_data,
    output logic               o_valid,
    output t_out_word          o_word
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_NEXT = 5'd1;
    localparam logic [4:0] S_DIFF = 5'd2;
    localparam logic [4:0] S_MAE  = 5'd3;
    localparam logic [4:0] S_MDB  = 5'd4;
    localparam logic [4:0] S_MCE  = 5'd5;
    localparam logic [4:0] S_MFB  = 5'd6;
    localparam logic [4:0] S_MCD  = 5'd7;
    localparam logic [4:0] S_MFA  = 5'd8;
    localparam logic [4:0] S_TEST = 5'd9;
    localparam logic [4:0] S_MSA  = 5'd10;
    localparam logic [4:0] S_DSX  = 5'd11;
    localparam logic [4:0] S_WX   = 5'd12;
    localparam logic [4:0] S_MSD  = 5'd13;
    localparam logic [4:0] S_DSY  = 5'd14;
    localparam logic [4:0] S_WY   = 5'd15;
    localparam logic [4:0] S_SQX  = 5'd16;
    localparam logic [4:0] S_SQY  = 5'd17;
    localparam logic [4:0] S_DSUM = 5'd18;
    localparam logic [4:0] S_DONE = 5'd19;

    logic [4:0]                r_state, n_state;
    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        r_idx;
    logic [COUNT_W-1:0]        w_limit;

    // ray
    logic signed [COORD_W-1:0] r_x1, r_y1;
    logic signed [DIFF_W-1:0]  r_a, r_d;
    // current wall
    logic signed [DIFF_W-1:0]  r_b, r_e, r_c, r_f;
    // cross terms
    logic signed [33:0]        r_acc;
    logic signed [CROSS_W-1:0] r_delta, r_s;
    logic [MAG_W-1:0]          r_dabs, r_sabs;
    logic [QUOT_W-1:0]         r_ux, r_uy;
    logic [47:0]               r_sq;
    // shared multiplier
    logic signed [35:0]        w_ma;
    logic signed [24:0]        w_mb;
    logic signed [60:0]        r_prod;
    // best hit so far
    logic                      r_found;
    logic [DIST_W-1:0]         r_best;
    logic [23:0]               r_bx, r_by;
    logic [SLOT_W-1:0]         r_bi;
    // output
    logic                      r_valid;
    t_out_word                 r_out;

    t_seg                      w_rd;
    t_seg                      w_wdata;
    logic                      w_accept;
    logic                      w_we;

    logic signed [CROSS_W-1:0] w_prod_lo, w_t, w_dn, w_sn, w_tn;
    logic                      w_neg, w_hit;
    logic [DIFF_W-1:0]         w_aabs, w_dabs;
    logic                      w_div_start, w_div_done;
    logic [NUM_W-1:0]          w_div_num;
    logic [QUOT_W-1:0]         w_quot;
    logic [DIST_W-1:0]         w_dist;
    logic [QUOT_W:0]           w_qx, w_qy;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_we     = w_accept && (i_word.opcode == OP_WRITE);
    assign w_limit  = (r_count > COUNT_W'(MAX_SEGMENTS)) ? COUNT_W'(MAX_SEGMENTS) : r_count;

    assign w_wdata.x3 = i_word.start_x;
    assign w_wdata.y3 = i_word.start_y;
    assign w_wdata.x4 = i_word.end_x;
    assign w_wdata.y4 = i_word.end_y;

    // segment store
    nsrh_table u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_word.slot),
        .i_wdata (w_wdata),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (w_rd)
    );

    // shared divider for the hit offsets
    assign w_div_start = (r_state == S_DSX) || (r_state == S_DSY);
    assign w_div_num   = r_prod[NUM_W-1:0];

    nsrh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_dabs),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // magnitudes of the ray direction
    assign w_aabs = r_a[DIFF_W-1] ? DIFF_W'(-r_a) : DIFF_W'(r_a);
    assign w_dabs = r_d[DIFF_W-1] ? DIFF_W'(-r_d) : DIFF_W'(r_d);

    // multiplier operand select
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_state)
            S_MAE: begin
                w_ma = {{19{r_a[16]}}, r_a};
                w_mb = {{8{r_e[16]}}, r_e};
            end
            S_MDB: begin
                w_ma = {{19{r_d[16]}}, r_d};
                w_mb = {{8{r_b[16]}}, r_b};
            end
            S_MCE: begin
                w_ma = {{19{r_c[16]}}, r_c};
                w_mb = {{8{r_e[16]}}, r_e};
            end
            S_MFB: begin
                w_ma = {{19{r_f[16]}}, r_f};
                w_mb = {{8{r_b[16]}}, r_b};
            end
            S_MCD: begin
                w_ma = {{19{r_c[16]}}, r_c};
                w_mb = {{8{r_d[16]}}, r_d};
            end
            S_MFA: begin
                w_ma = {{19{r_f[16]}}, r_f};
                w_mb = {{8{r_a[16]}}, r_a};
            end
            S_MSA: begin
                w_ma = {2'b00, r_sabs};
                w_mb = {8'd0, w_aabs};
            end
            S_MSD: begin
                w_ma = {2'b00, r_sabs};
                w_mb = {8'd0, w_dabs};
            end
            S_SQX: begin
                w_ma = {12'd0, r_ux};
                w_mb = {1'b0, r_ux};
            end
            S_SQY: begin
                w_ma = {12'd0, r_uy};
                w_mb = {1'b0, r_uy};
            end
            default: begin
                w_ma = '0;
                w_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_ma * w_mb;
    end

    // hit test on the sign-normalized cross terms
    assign w_prod_lo = {r_prod[33], r_prod[33:0]};
    assign w_t   = {r_acc[33], r_acc} - w_prod_lo;
    assign w_neg = r_delta[CROSS_W-1];
    assign w_dn  = w_neg ? -r_delta : r_delta;
    assign w_sn  = w_neg ? -r_s : r_s;
    assign w_tn  = w_neg ? -w_t : w_t;
    assign w_hit = (r_delta != '0) && (w_sn >= 0) && (w_sn <= w_dn)
                   && (w_tn >= 0) && (w_tn <= w_dn);

    // squared distance and signed offsets
    assign w_dist = DIST_W'(r_sq) + DIST_W'(r_prod[47:0]);
    assign w_qx   = r_a[DIFF_W-1] ? -{1'b0, r_ux} : {1'b0, r_ux};
    assign w_qy   = r_d[DIFF_W-1] ? -{1'b0, r_uy} : {1'b0, r_uy};

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept && (i_word.opcode == OP_CAST)) n_state = S_NEXT;
            S_NEXT: n_state = (r_idx < w_limit) ? S_DIFF : S_DONE;
            S_DIFF: n_state = S_MAE;
            S_MAE:  n_state = S_MDB;
            S_MDB:  n_state = S_MCE;
            S_MCE:  n_state = S_MFB;
            S_MFB:  n_state = S_MCD;
            S_MCD:  n_state = S_MFA;
            S_MFA:  n_state = S_TEST;
            S_TEST: n_state = w_hit ? S_MSA : S_NEXT;
            S_MSA:  n_state = S_DSX;
            S_DSX:  n_state = S_WX;
            S_WX:   if (w_div_done) n_state = S_MSD;
            S_MSD:  n_state = S_DSY;
            S_DSY:  n_state = S_WY;
            S_WY:   if (w_div_done) n_state = S_SQX;
            S_SQX:  n_state = S_SQY;
            S_SQY:  n_state = S_DSUM;
            S_DSUM: n_state = S_NEXT;
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == S_DONE);
            if (i_cfg_we) begin
                r_count <= i_cfg_data;
            end
            if (r_state == S_IDLE) begin
                r_idx   <= '0;
                r_found <= 1'b0;
            end
            if (((r_state == S_TEST) && !w_hit) || (r_state == S_DSUM)) begin
                r_idx <= r_idx + COUNT_W'(1);
            end
            if ((r_state == S_DSUM) && (!r_found || (w_dist < r_best))) begin
                r_found <= 1'b1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x1 <= i_word.start_x;
            r_y1 <= i_word.start_y;
            r_a  <= {i_word.end_x[15], i_word.end_x} - {i_word.start_x[15], i_word.start_x};
            r_d  <= {i_word.end_y[15], i_word.end_y} - {i_word.start_y[15], i_word.start_y};
        end
        case (r_state)
            S_DIFF: begin
                r_b <= {w_rd.x4[15], w_rd.x4} - {w_rd.x3[15], w_rd.x3};
                r_e <= {w_rd.y4[15], w_rd.y4} - {w_rd.y3[15], w_rd.y3};
                r_c <= {w_rd.x3[15], w_rd.x3} - {r_x1[15], r_x1};
                r_f <= {w_rd.y3[15], w_rd.y3} - {r_y1[15], r_y1};
            end
            S_MDB, S_MFB, S_MFA: r_acc <= r_prod[33:0];
            S_MCE: r_delta <= {r_acc[33], r_acc} - w_prod_lo;
            S_MCD: r_s     <= {r_acc[33], r_acc} - w_prod_lo;
            S_TEST: begin
                r_dabs <= w_dn[MAG_W-1:0];
                r_sabs <= w_sn[MAG_W-1:0];
            end
            S_WX:   if (w_div_done) r_ux <= w_quot;
            S_WY:   if (w_div_done) r_uy <= w_quot;
            S_SQY:  r_sq <= r_prod[47:0];
            default: begin
            end
        endcase
        // keep the nearest hit, the earlier index on a tie
        if ((r_state == S_DSUM) && (!r_found || (w_dist < r_best))) begin
            r_best <= w_dist;
            r_bx   <= {r_x1, 8'd0} + w_qx[23:0];
            r_by   <= {r_y1, 8'd0} + w_qy[23:0];
            r_bi   <= r_idx[SLOT_W-1:0];
        end
        // result word
        if (r_state == S_DONE) begin
            r_out.hit              <= r_found;
            r_out.hit_x            <= r_found ? r_bx : '0;
            r_out.hit_y            <= r_found ? r_by : '0;
            r_out.distance_squared <= r_found ? r_best : '0;
            r_out.hit_segment      <= r_found ? r_bi : '0;
        end
    end

    assign o_valid = r_valid;
    assign o_word  = r_out;

endmodule

// ----- hw/rtl/nsrh_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// nsrh_checker
// Port-level checks for the nearest segment ray hit block.
// ---------------------------------------------------------------------------
module nsrh_checker
    import nsrh_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input t_in_word  i_word,
    input logic      o_valid,
    input t_out_word o_word
);

    // a cast word occupies the block
    a_cast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_word.opcode == OP_CAST)) |=> busy)
        else $error("cast word did not raise busy");

    // a write word does not raise busy
    a_write_quick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_word.opcode == OP_WRITE)) |=> !busy)
        else $error("write word held the block busy");

    // a result word only follows a busy cycle
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(busy))
        else $error("result word without a cast in progress");

    // one strobe per cast
    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // a miss reports all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_word.hit) |-> ((o_word.hit_segment == '0)
            && (o_word.distance_squared == '0) && (o_word.hit_x == '0)
            && (o_word.hit_y == '0)))
        else $error("miss word carries nonzero fields");

endmodule

bind nearest_segment_ray_hit_top nsrh_checker u_nsrh_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_word  (i_word),
    .o_valid (o_valid),
    .o_word  (o_word)
);
